[rtl/vtc_pkg.sv]
// Shared types, codes and helpers for the vertex transform about centroid unit.
// No dependencies; used by vtc_div, vtc_mac and the top level in rtl/.
package vtc_pkg;

    // Field and datapath widths
    localparam int SUM_W = 48;
    localparam int CNT_W = 17;
    localparam int OPA_W = 38;
    localparam int OPB_W = 17;
    localparam int PRD_W = OPA_W + OPB_W;
    localparam int ACC_W = 68;
    localparam int RES_W = 52;
    localparam int COUNT_CAP = 131071;

    // Input op codes
    localparam logic [1:0] OP_ACCUM = 2'd0;
    localparam logic [1:0] OP_XFORM = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Mode codes
    localparam logic [1:0] MODE_TRANSLATE = 2'd0;
    localparam logic [1:0] MODE_SCALE     = 2'd1;
    localparam logic [1:0] MODE_ROTATE    = 2'd2;

    // Config register indexes
    localparam logic [2:0] CFG_MODE = 3'd0;
    localparam logic [2:0] CFG_VX   = 3'd1;
    localparam logic [2:0] CFG_VY   = 3'd2;
    localparam logic [2:0] CFG_VZ   = 3'd3;
    localparam logic [2:0] CFG_QW   = 3'd4;
    localparam logic [2:0] CFG_QX   = 3'd5;
    localparam logic [2:0] CFG_QY   = 3'd6;
    localparam logic [2:0] CFG_QZ   = 3'd7;

    // Multiplier B operand select
    localparam logic [2:0] B_QW  = 3'd0;
    localparam logic [2:0] B_QX  = 3'd1;
    localparam logic [2:0] B_QY  = 3'd2;
    localparam logic [2:0] B_QZ  = 3'd3;
    localparam logic [2:0] B_SHI = 3'd4;
    localparam logic [2:0] B_SLO = 3'd5;

    // Rounding shift select
    localparam logic [1:0] SH13 = 2'd0;
    localparam logic [1:0] SH14 = 2'd1;
    localparam logic [1:0] SH16 = 2'd2;

    // Last step of each micro-program
    localparam logic [3:0] SCL_LAST = 4'd5;
    localparam logic [3:0] ROT_LAST = 4'd14;

    // One step of the multiply-accumulate sequencer
    typedef struct packed {
        logic       a_t;     // A from t vector, else from v vector
        logic [1:0] a_idx;
        logic [2:0] b_sel;
        logic       neg;     // subtract product
        logic       first;   // restart accumulator
        logic       last;    // write shifted result
        logic [1:0] sh;
        logic       psh16;   // product weighted by 2^16
        logic       base;    // seed accumulator with base value
        logic       d_t;     // result goes to t, else to result regs
        logic [1:0] d_idx;
    } t_uop;

    function automatic t_uop mk(input logic a_t, input logic [1:0] a_idx,
                                input logic [2:0] b_sel, input logic neg,
                                input logic first, input logic last,
                                input logic [1:0] sh, input logic psh16,
                                input logic base, input logic d_t,
                                input logic [1:0] d_idx);
        t_uop u;
        u.a_t = a_t; u.a_idx = a_idx; u.b_sel = b_sel; u.neg = neg;
        u.first = first; u.last = last; u.sh = sh; u.psh16 = psh16;
        u.base = base; u.d_t = d_t; u.d_idx = d_idx;
        return u;
    endfunction

    // Rotation: t = rnd(q x v, 13), then r = base + rnd(w*t + q x t, 14)
    function automatic t_uop uop_rot(input logic [3:0] k);
        t_uop u;
        case (k)
            4'd0:  u = mk(1'b0, 2'd2, B_QY, 1'b0, 1'b1, 1'b0, SH13, 1'b0, 1'b0, 1'b1, 2'd0);
            4'd1:  u = mk(1'b0, 2'd1, B_QZ, 1'b1, 1'b0, 1'b1, SH13, 1'b0, 1'b0, 1'b1, 2'd0);
            4'd2:  u = mk(1'b0, 2'd0, B_QZ, 1'b0, 1'b1, 1'b0, SH13, 1'b0, 1'b0, 1'b1, 2'd1);
            4'd3:  u = mk(1'b0, 2'd2, B_QX, 1'b1, 1'b0, 1'b1, SH13, 1'b0, 1'b0, 1'b1, 2'd1);
            4'd4:  u = mk(1'b0, 2'd1, B_QX, 1'b0, 1'b1, 1'b0, SH13, 1'b0, 1'b0, 1'b1, 2'd2);
            4'd5:  u = mk(1'b0, 2'd0, B_QY, 1'b1, 1'b0, 1'b1, SH13, 1'b0, 1'b0, 1'b1, 2'd2);
            4'd6:  u = mk(1'b1, 2'd0, B_QW, 1'b0, 1'b1, 1'b0, SH14, 1'b0, 1'b1, 1'b0, 2'd0);
            4'd7:  u = mk(1'b1, 2'd2, B_QY, 1'b0, 1'b0, 1'b0, SH14, 1'b0, 1'b0, 1'b0, 2'd0);
            4'd8:  u = mk(1'b1, 2'd1, B_QZ, 1'b1, 1'b0, 1'b1, SH14, 1'b0, 1'b0, 1'b0, 2'd0);
            4'd9:  u = mk(1'b1, 2'd1, B_QW, 1'b0, 1'b1, 1'b0, SH14, 1'b0, 1'b1, 1'b0, 2'd1);
            4'd10: u = mk(1'b1, 2'd0, B_QZ, 1'b0, 1'b0, 1'b0, SH14, 1'b0, 1'b0, 1'b0, 2'd1);
            4'd11: u = mk(1'b1, 2'd2, B_QX, 1'b1, 1'b0, 1'b1, SH14, 1'b0, 1'b0, 1'b0, 2'd1);
            4'd12: u = mk(1'b1, 2'd2, B_QW, 1'b0, 1'b1, 1'b0, SH14, 1'b0, 1'b1, 1'b0, 2'd2);
            4'd13: u = mk(1'b1, 2'd1, B_QX, 1'b0, 1'b0, 1'b0, SH14, 1'b0, 1'b0, 1'b0, 2'd2);
            4'd14: u = mk(1'b1, 2'd0, B_QY, 1'b1, 1'b0, 1'b1, SH14, 1'b0, 1'b0, 1'b0, 2'd2);
            default: u = '0;
        endcase
        return u;
    endfunction

    // Scale: r = c + rnd(d * s, 16), s split in signed high and unsigned low half
    function automatic t_uop uop_scl(input logic [3:0] k);
        t_uop u;
        case (k)
            4'd0: u = mk(1'b0, 2'd0, B_SHI, 1'b0, 1'b1, 1'b0, SH16, 1'b1, 1'b1, 1'b0, 2'd0);
            4'd1: u = mk(1'b0, 2'd0, B_SLO, 1'b0, 1'b0, 1'b1, SH16, 1'b0, 1'b0, 1'b0, 2'd0);
            4'd2: u = mk(1'b0, 2'd1, B_SHI, 1'b0, 1'b1, 1'b0, SH16, 1'b1, 1'b1, 1'b0, 2'd1);
            4'd3: u = mk(1'b0, 2'd1, B_SLO, 1'b0, 1'b0, 1'b1, SH16, 1'b0, 1'b0, 1'b0, 2'd1);
            4'd4: u = mk(1'b0, 2'd2, B_SHI, 1'b0, 1'b1, 1'b0, SH16, 1'b1, 1'b1, 1'b0, 2'd2);
            4'd5: u = mk(1'b0, 2'd2, B_SLO, 1'b0, 1'b0, 1'b1, SH16, 1'b0, 1'b0, 1'b0, 2'd2);
            default: u = '0;
        endcase
        return u;
    endfunction

    // Saturation to 32 and 16 bits
    localparam logic signed [RES_W-1:0] P_HI = 52'sd2147483647;
    localparam logic signed [RES_W-1:0] P_LO = -52'sd2147483648;
    localparam logic signed [RES_W-1:0] N_HI = 52'sd32767;
    localparam logic signed [RES_W-1:0] N_LO = -52'sd32768;

    function automatic logic [31:0] sat32(input logic signed [RES_W-1:0] v);
        logic [31:0] r;
        if (v > P_HI) r = 32'h7fff_ffff;
        else if (v < P_LO) r = 32'h8000_0000;
        else r = v[31:0];
        return r;
    endfunction

    function automatic logic ovf32(input logic signed [RES_W-1:0] v);
        return (v > P_HI) || (v < P_LO);
    endfunction

    function automatic logic [15:0] sat16(input logic signed [RES_W-1:0] v);
        logic [15:0] r;
        if (v > N_HI) r = 16'h7fff;
        else if (v < N_LO) r = 16'h8000;
        else r = v[15:0];
        return r;
    endfunction

    function automatic logic ovf16(input logic signed [RES_W-1:0] v);
        return (v > N_HI) || (v < N_LO);
    endfunction

endpackage

[rtl/vtc_if.sv]
// Valid/ready channel interfaces for the vertex transform unit.
// Input channel carries one vertex transaction, output channel one result.
interface vtc_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] norm_x;
    logic signed [15:0] norm_y;
    logic signed [15:0] norm_z;

    modport source (output valid, op, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                    input ready);
    modport sink (input valid, op, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                  output ready);
endinterface

interface vtc_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic signed [15:0] out_nx;
    logic signed [15:0] out_ny;
    logic signed [15:0] out_nz;
    logic               saturated;

    modport source (output valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
                    saturated, input ready);
    modport sink (input valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
                  saturated, output ready);
endinterface

[rtl/vtc_div.sv]
// Bit-serial signed divider for the centroid: 48-bit sum by 17-bit count.
// Truncates toward zero, clamps to 32 bits, gives zero for a zero count. Uses vtc_pkg.
module vtc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [vtc_pkg::SUM_W-1:0]      i_sum,
    input  logic [vtc_pkg::CNT_W-1:0]      i_cnt,
    output logic                           o_done,
    output logic signed [31:0]             o_quo
);
    localparam logic [5:0] LAST = 6'(vtc_pkg::SUM_W - 1);

    logic                        r_busy, r_done;
    logic [5:0]                  r_n;
    logic [vtc_pkg::SUM_W-1:0]   r_dvd;
    logic [vtc_pkg::CNT_W-1:0]   r_rem, r_div;
    logic                        r_neg, r_zero;
    logic [vtc_pkg::CNT_W:0]     w_trial;
    logic                        w_ge;

    // One quotient bit per cycle
    assign w_trial = {r_rem, r_dvd[vtc_pkg::SUM_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_n    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_n    <= '0;
            end else if (r_busy) begin
                r_n <= r_n + 6'd1;
                if (r_n == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg  <= i_sum[vtc_pkg::SUM_W-1];
            r_dvd  <= i_sum[vtc_pkg::SUM_W-1] ? (~i_sum + 1'b1) : i_sum;
            r_div  <= i_cnt;
            r_zero <= (i_cnt == '0);
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_trial[vtc_pkg::CNT_W-1:0] - r_div)
                          : w_trial[vtc_pkg::CNT_W-1:0];
            r_dvd <= {r_dvd[vtc_pkg::SUM_W-2:0], w_ge};
        end
    end

    // Sign and clamp of the magnitude quotient
    always_comb begin
        if (r_zero) begin
            o_quo = '0;
        end else if (r_neg) begin
            if (r_dvd > 48'd2147483648) o_quo = 32'sh8000_0000;
            else o_quo = -$signed(r_dvd[31:0]);
        end else begin
            if (r_dvd > 48'd2147483647) o_quo = 32'sh7fff_ffff;
            else o_quo = $signed(r_dvd[31:0]);
        end
    end

    assign o_done = r_done;
endmodule

[rtl/vtc_mac.sv]
// Shared multiply-accumulate unit: one 38x17 signed multiplier and a 68-bit accumulator.
// Each step seeds or adds to the accumulator; result is the rounded right shift. Uses vtc_pkg.
module vtc_mac (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  vtc_pkg::t_uop                       i_uop,
    input  logic signed [vtc_pkg::OPA_W-1:0]    i_a,
    input  logic signed [vtc_pkg::OPB_W-1:0]    i_b,
    input  logic signed [32:0]                  i_base,
    output logic signed [vtc_pkg::RES_W-1:0]    o_res
);
    logic signed [vtc_pkg::ACC_W-1:0] r_acc;
    logic signed [vtc_pkg::PRD_W-1:0] w_prod;
    logic signed [vtc_pkg::ACC_W-1:0] w_px, w_bx, w_init, w_start, n_acc, w_shr;

    assign w_prod = i_a * i_b;

    always_comb begin
        // Product, optionally weighted by 2^16
        w_px = {{(vtc_pkg::ACC_W - vtc_pkg::PRD_W){w_prod[vtc_pkg::PRD_W-1]}}, w_prod};
        if (i_uop.psh16) w_px = w_px <<< 16;

        // Seed: base scaled up plus half an LSB of the final shift
        w_bx = i_uop.base ? {{(vtc_pkg::ACC_W - 33){i_base[32]}}, i_base} : '0;
        case (i_uop.sh)
            vtc_pkg::SH13: w_init = (w_bx <<< 13) + 68'sd4096;
            vtc_pkg::SH14: w_init = (w_bx <<< 14) + 68'sd8192;
            vtc_pkg::SH16: w_init = (w_bx <<< 16) + 68'sd32768;
            default:       w_init = w_bx;
        endcase

        w_start = i_uop.first ? w_init : r_acc;
        n_acc   = i_uop.neg ? (w_start - w_px) : (w_start + w_px);

        case (i_uop.sh)
            vtc_pkg::SH13: w_shr = n_acc >>> 13;
            vtc_pkg::SH14: w_shr = n_acc >>> 14;
            vtc_pkg::SH16: w_shr = n_acc >>> 16;
            default:       w_shr = n_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_acc <= n_acc;
    end

    assign o_res = w_shr[vtc_pkg::RES_W-1:0];
endmodule

[rtl/vertex_transform_about_centroid_unit.sv]
// Top level of the vertex transform about centroid unit: sequencer, state and config.
// Depends on vtc_pkg, vtc_if (channels), vtc_div and vtc_mac.
//
// One transaction at a time; in.ready is high only while the unit is idle and no
// result is held. In scale and rotate mode a transform is run as steps of the
// shared multiply-accumulate unit (two per axis for scale, fifteen per vector for
// rotation, position and normal). The centroid is cached; the first transform after
// a counted accumulate or a clear first runs three 48-step serial divisions. The
// result then waits in an output register until taken. MAX_VERTICES caps how many
// accumulates are counted (at most 131071).
module vertex_transform_about_centroid_unit #(
    parameter int MAX_VERTICES = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    vtc_in_if.sink      i_in,
    vtc_out_if.source   o_out,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);
    localparam int LIMIT_I = (MAX_VERTICES < vtc_pkg::COUNT_CAP) ? MAX_VERTICES
                                                                 : vtc_pkg::COUNT_CAP;
    localparam logic [vtc_pkg::CNT_W-1:0] LIMIT = LIMIT_I[vtc_pkg::CNT_W-1:0];

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_DSET = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // Config
    logic [1:0]          r_mode;
    logic signed [31:0]  r_vec [3];
    logic signed [15:0]  r_qw, r_qx, r_qy, r_qz;

    // Control
    logic [2:0]                 r_state;
    logic [1:0]                 r_axis;
    logic [3:0]                 r_k;
    logic                       r_pass;
    logic                       r_div_go;
    logic                       r_cvalid;
    logic                       r_ov;
    logic [vtc_pkg::SUM_W-1:0]  r_sum [3];
    logic [vtc_pkg::CNT_W-1:0]  r_cnt;

    // Payload
    logic signed [31:0]                r_c [3];
    logic signed [31:0]                r_p [3];
    logic signed [15:0]                r_n [3];
    logic signed [vtc_pkg::OPA_W-1:0]  r_v [3];
    logic signed [vtc_pkg::OPA_W-1:0]  r_t [3];
    logic signed [vtc_pkg::RES_W-1:0]  r_res [3];
    logic signed [vtc_pkg::RES_W-1:0]  r_nres [3];
    logic [31:0]                       r_ox [3];
    logic [15:0]                       r_on [3];
    logic                              r_sat;

    logic                              w_in_acc, w_div_done;
    logic signed [31:0]                w_quo;
    vtc_pkg::t_uop                     w_uop;
    logic                              w_last_step;
    logic signed [vtc_pkg::OPA_W-1:0]  w_a;
    logic signed [vtc_pkg::OPB_W-1:0]  w_b;
    logic signed [32:0]                w_base;
    logic signed [vtc_pkg::RES_W-1:0]  w_res;
    logic signed [vtc_pkg::RES_W-1:0]  w_pos [3];
    logic signed [vtc_pkg::RES_W-1:0]  w_nrm [3];

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);

    // Centroid divider
    vtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_sum   (r_sum[r_axis]),
        .i_cnt   (r_cnt),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // Operand selection for the shared multiply-accumulate unit
    always_comb begin
        w_uop = (r_mode == vtc_pkg::MODE_SCALE) ? vtc_pkg::uop_scl(r_k)
                                                : vtc_pkg::uop_rot(r_k);
        w_last_step = (r_mode == vtc_pkg::MODE_SCALE) ? (r_k == vtc_pkg::SCL_LAST)
                                                      : (r_k == vtc_pkg::ROT_LAST);
        w_a = w_uop.a_t ? r_t[w_uop.a_idx] : r_v[w_uop.a_idx];
        case (w_uop.b_sel)
            vtc_pkg::B_QW:  w_b = {r_qw[15], r_qw};
            vtc_pkg::B_QX:  w_b = {r_qx[15], r_qx};
            vtc_pkg::B_QY:  w_b = {r_qy[15], r_qy};
            vtc_pkg::B_QZ:  w_b = {r_qz[15], r_qz};
            vtc_pkg::B_SHI: w_b = {r_vec[w_uop.a_idx][31], r_vec[w_uop.a_idx][31:16]};
            vtc_pkg::B_SLO: w_b = {1'b0, r_vec[w_uop.a_idx][15:0]};
            default:        w_b = '0;
        endcase
        if (r_mode == vtc_pkg::MODE_SCALE)
            w_base = {r_c[w_uop.d_idx][31], r_c[w_uop.d_idx]};
        else if (r_pass)
            w_base = {{17{r_n[w_uop.d_idx][15]}}, r_n[w_uop.d_idx]};
        else
            w_base = {r_p[w_uop.d_idx][31], r_p[w_uop.d_idx]};
    end

    vtc_mac u_mac (
        .i_clk  (i_clk),
        .i_en   (r_state == S_MUL),
        .i_uop  (w_uop),
        .i_a    (w_a),
        .i_b    (w_b),
        .i_base (w_base),
        .o_res  (w_res)
    );

    // Pre-saturation results per mode
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_nrm[i] = {{(vtc_pkg::RES_W - 16){r_n[i][15]}}, r_n[i]};
            case (r_mode)
                vtc_pkg::MODE_TRANSLATE:
                    w_pos[i] = {{(vtc_pkg::RES_W - 32){r_p[i][31]}}, r_p[i]}
                             + {{(vtc_pkg::RES_W - 32){r_vec[i][31]}}, r_vec[i]};
                vtc_pkg::MODE_SCALE:
                    w_pos[i] = r_res[i];
                vtc_pkg::MODE_ROTATE: begin
                    w_pos[i] = r_res[i];
                    w_nrm[i] = r_nres[i];
                end
                default:
                    w_pos[i] = {{(vtc_pkg::RES_W - 32){r_p[i][31]}}, r_p[i]};
            endcase
        end
    end

    // Config, sums and sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= vtc_pkg::MODE_TRANSLATE;
            r_vec[0] <= '0;
            r_vec[1] <= '0;
            r_vec[2] <= '0;
            r_qw     <= 16'sd16384;
            r_qx     <= '0;
            r_qy     <= '0;
            r_qz     <= '0;
            r_state  <= S_IDLE;
            r_axis   <= '0;
            r_k      <= '0;
            r_pass   <= 1'b0;
            r_div_go <= 1'b0;
            r_cvalid <= 1'b0;
            r_ov     <= 1'b0;
            r_sum[0] <= '0;
            r_sum[1] <= '0;
            r_sum[2] <= '0;
            r_cnt    <= '0;
        end else begin
            r_div_go <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    vtc_pkg::CFG_MODE: r_mode   <= i_cfg_data[1:0];
                    vtc_pkg::CFG_VX:   r_vec[0] <= i_cfg_data;
                    vtc_pkg::CFG_VY:   r_vec[1] <= i_cfg_data;
                    vtc_pkg::CFG_VZ:   r_vec[2] <= i_cfg_data;
                    vtc_pkg::CFG_QW:   r_qw     <= i_cfg_data[15:0];
                    vtc_pkg::CFG_QX:   r_qx     <= i_cfg_data[15:0];
                    vtc_pkg::CFG_QY:   r_qy     <= i_cfg_data[15:0];
                    vtc_pkg::CFG_QZ:   r_qz     <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        case (i_in.op)
                            vtc_pkg::OP_ACCUM: begin
                                if (r_cnt < LIMIT) begin
                                    r_sum[0] <= r_sum[0] + {{16{i_in.pos_x[31]}}, i_in.pos_x};
                                    r_sum[1] <= r_sum[1] + {{16{i_in.pos_y[31]}}, i_in.pos_y};
                                    r_sum[2] <= r_sum[2] + {{16{i_in.pos_z[31]}}, i_in.pos_z};
                                    r_cnt    <= r_cnt + 1'b1;
                                    r_cvalid <= 1'b0;
                                end
                            end
                            vtc_pkg::OP_CLEAR: begin
                                r_sum[0] <= '0;
                                r_sum[1] <= '0;
                                r_sum[2] <= '0;
                                r_cnt    <= '0;
                                r_cvalid <= 1'b0;
                            end
                            vtc_pkg::OP_XFORM: begin
                                if (r_cvalid) begin
                                    r_state <= S_DSET;
                                end else begin
                                    r_state  <= S_DIV;
                                    r_axis   <= '0;
                                    r_div_go <= 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        if (r_axis == 2'd2) begin
                            r_cvalid <= 1'b1;
                            r_state  <= S_DSET;
                        end else begin
                            r_axis   <= r_axis + 2'd1;
                            r_div_go <= 1'b1;
                        end
                    end
                end
                S_DSET: begin
                    r_k    <= '0;
                    r_pass <= 1'b0;
                    if (r_mode == vtc_pkg::MODE_SCALE || r_mode == vtc_pkg::MODE_ROTATE)
                        r_state <= S_MUL;
                    else
                        r_state <= S_FIN;
                end
                S_MUL: begin
                    if (w_last_step) begin
                        r_k <= '0;
                        if (r_mode == vtc_pkg::MODE_ROTATE && !r_pass)
                            r_pass <= 1'b1;
                        else
                            r_state <= S_FIN;
                    end else begin
                        r_k <= r_k + 4'd1;
                    end
                end
                S_FIN: begin
                    r_ov    <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_ov    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_p[0] <= i_in.pos_x;
            r_p[1] <= i_in.pos_y;
            r_p[2] <= i_in.pos_z;
            r_n[0] <= i_in.norm_x;
            r_n[1] <= i_in.norm_y;
            r_n[2] <= i_in.norm_z;
        end
        if (r_state == S_DIV && w_div_done)
            r_c[r_axis] <= w_quo;
        // Offset from centroid
        if (r_state == S_DSET) begin
            for (int i = 0; i < 3; i++)
                r_v[i] <= {{(vtc_pkg::OPA_W - 32){r_p[i][31]}}, r_p[i]}
                        - {{(vtc_pkg::OPA_W - 32){r_c[i][31]}}, r_c[i]};
        end
        if (r_state == S_MUL) begin
            if (w_uop.last) begin
                if (w_uop.d_t)
                    r_t[w_uop.d_idx] <= w_res[vtc_pkg::OPA_W-1:0];
                else if (r_pass)
                    r_nres[w_uop.d_idx] <= w_res;
                else
                    r_res[w_uop.d_idx] <= w_res;
            end
            // Switch the rotation from position to normal
            if (w_last_step && r_mode == vtc_pkg::MODE_ROTATE && !r_pass) begin
                for (int i = 0; i < 3; i++)
                    r_v[i] <= {{(vtc_pkg::OPA_W - 16){r_n[i][15]}}, r_n[i]};
            end
        end
        if (r_state == S_FIN) begin
            for (int i = 0; i < 3; i++) begin
                r_ox[i] <= vtc_pkg::sat32(w_pos[i]);
                r_on[i] <= vtc_pkg::sat16(w_nrm[i]);
            end
            r_sat <= vtc_pkg::ovf32(w_pos[0]) | vtc_pkg::ovf32(w_pos[1])
                   | vtc_pkg::ovf32(w_pos[2]) | vtc_pkg::ovf16(w_nrm[0])
                   | vtc_pkg::ovf16(w_nrm[1]) | vtc_pkg::ovf16(w_nrm[2]);
        end
    end

    assign o_out.valid     = r_ov;
    assign o_out.out_x     = r_ox[0];
    assign o_out.out_y     = r_ox[1];
    assign o_out.out_z     = r_ox[2];
    assign o_out.out_nx    = r_on[0];
    assign o_out.out_ny    = r_on[1];
    assign o_out.out_nz    = r_on[2];
    assign o_out.saturated = r_sat;

    // The input side is closed while a result is held
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input ready while result pending");

    // A transform never answers in the next cycle
    a_xform_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_in.op == vtc_pkg::OP_XFORM) |=> !o_out.valid)
        else $error("transform result too early");

    // Vertex count stays within its cap
    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= LIMIT)
        else $error("vertex count beyond limit");

    // Divider only finishes while centroids are being computed
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider done outside centroid state");
endmodule
